/* design/sdspi_pkg.sv */
// Shared types and constants for the SD card SPI-mode host sequencer.
// No dependencies; used by sd_card_spi_host_sequencer.
`default_nettype none

package sdspi_pkg;

  // Geometry and limits of the sequencer.
  localparam int unsigned ADDR_W = 9;
  localparam logic [9:0] BLOCK_BYTES = 10'd512;
  localparam logic [9:0] DUMMY_BYTES = 10'd10;
  localparam logic [9:0] CMD_BYTES = 10'd6;
  localparam logic [9:0] CRC_BYTES = 10'd2;
  localparam logic [3:0] POLL_LIMIT = 4'd10;

  // Fixed bytes on the wire.
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] CMD_PREFIX = 8'h40;
  localparam logic [7:0] CRC_CMD0 = 8'h95;
  localparam logic [7:0] CRC_CMD8 = 8'h87;
  localparam logic [7:0] CRC_OTHER = 8'h01;
  localparam logic [7:0] R1_IDLE = 8'h01;
  localparam logic [7:0] R1_READY = 8'h00;
  localparam logic [4:0] DRESP_MASKED_OK = 5'h05;

  // Command indexes used by the sequencer.
  localparam logic [5:0] IDX_GO_IDLE = 6'd0;
  localparam logic [5:0] IDX_IF_COND = 6'd8;
  localparam logic [5:0] IDX_WRITE_BLOCK = 6'd24;
  localparam logic [5:0] IDX_OP_COND = 6'd41;
  localparam logic [5:0] IDX_APP_CMD = 6'd55;

  // Command arguments.
  localparam logic [31:0] ARG_NONE = 32'h0000_0000;
  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_OP_COND = 32'h4000_0000;

  // Input word command codes.
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CARD  = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  // Completion status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IDLE_ERR = 2'd1,
    ST_WR_REJ   = 2'd2,
    ST_DATA_REJ = 2'd3
  } status_t;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_DUMMY = 4'd1,
    PH_CMD   = 4'd2,
    PH_POLL  = 4'd3,
    PH_END   = 4'd4,
    PH_TOKEN = 4'd5,
    PH_DATA  = 4'd6,
    PH_CRC   = 4'd7,
    PH_DRESP = 4'd8,
    PH_BUSY  = 4'd9
  } phase_t;

  // Input word.
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] block_address;
    logic [8:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [7:0]  card_byte;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       select_active;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  // Byte k of a six-byte command frame.
  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] crc;
    crc = (idx == IDX_GO_IDLE) ? CRC_CMD0 : ((idx == IDX_IF_COND) ? CRC_CMD8 : CRC_OTHER);
    unique case (k)
      3'd0:    frame_byte = CMD_PREFIX | {2'b00, idx};
      3'd1:    frame_byte = arg[31:24];
      3'd2:    frame_byte = arg[23:16];
      3'd3:    frame_byte = arg[15:8];
      3'd4:    frame_byte = arg[7:0];
      default: frame_byte = crc;
    endcase
  endfunction

endpackage

`default_nettype wire

/* design/sd_card_spi_host_sequencer.sv */
// SD card SPI-mode host sequencer: init sequence and single-block write.
// Accepted words wait in the input stage register; results are registered.
// Throughput: one input word per cycle; the only stall is a full result register.
// Payload bytes sit in a 512 x 8 memory whose read word is prefetched.
// Reset (synchronous, rst_n low) returns to idle with empty stages; the payload
// memory is not cleared and must be loaded before a block write.
`default_nettype none

module sd_card_spi_host_sequencer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sdspi_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sdspi_pkg::out_t       out_data
);

  // Input stage register.
  logic            st_valid_r;
  sdspi_pkg::in_t  st_item_r;

  // Sequencer state.
  sdspi_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]        byte_counter_r, byte_counter_nxt;
  logic [3:0]        poll_counter_r, poll_counter_nxt;
  logic [31:0]       current_argument_r, current_argument_nxt;
  logic [5:0]        current_index_r, current_index_nxt;
  logic [7:0]        saved_response_r, saved_response_nxt;

  // Payload memory and its prefetched read word.
  logic [7:0]                     payload_mem [sdspi_pkg::BLOCK_BYTES];
  logic [7:0]                     rd_data_r;
  logic [sdspi_pkg::ADDR_W-1:0]   rd_addr;
  logic                           wr_en;

  // Result register.
  logic            out_valid_r;
  sdspi_pkg::out_t out_data_r;

  // Step results.
  logic            proc;
  logic            res_valid;
  sdspi_pkg::out_t res;

  // The stage advances unless a result still waits and is not being taken.
  assign proc     = st_valid_r && !(out_valid_r && !out_ready);
  assign in_ready = !st_valid_r || proc;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer step for the word in the stage register.
  always_comb begin
    logic              start;
    logic [5:0]        start_idx;
    logic [31:0]       start_arg;
    logic              end_op;
    logic [1:0]        end_status;
    logic [9:0]        cnt_inc;
    logic [3:0]        poll_inc;
    logic [7:0]        b;
    sdspi_pkg::cmd_t   cmd;

    phase_nxt            = phase_r;
    byte_counter_nxt     = byte_counter_r;
    poll_counter_nxt     = poll_counter_r;
    current_argument_nxt = current_argument_r;
    current_index_nxt    = current_index_r;
    saved_response_nxt   = saved_response_r;
    res_valid            = 1'b0;
    res                  = '0;
    wr_en                = 1'b0;
    start                = 1'b0;
    start_idx            = sdspi_pkg::IDX_GO_IDLE;
    start_arg            = sdspi_pkg::ARG_NONE;
    end_op               = 1'b0;
    end_status           = sdspi_pkg::ST_OK;
    cnt_inc              = byte_counter_r + 10'd1;
    poll_inc             = poll_counter_r + 4'd1;
    b                    = st_item_r.card_byte;
    cmd                  = sdspi_pkg::cmd_t'(st_item_r.command);

    if (proc) begin
      unique case (cmd)
        sdspi_pkg::CMD_LOAD: begin
          wr_en = 1'b1;
        end
        sdspi_pkg::CMD_INIT: begin
          if (phase_r == sdspi_pkg::PH_IDLE) begin
            phase_nxt        = sdspi_pkg::PH_DUMMY;
            byte_counter_nxt = '0;
            res_valid        = 1'b1;
            res.tx_byte      = sdspi_pkg::IDLE_BYTE;
            res.tx_valid     = 1'b1;
          end
        end
        sdspi_pkg::CMD_WRITE: begin
          if (phase_r == sdspi_pkg::PH_IDLE) begin
            start     = 1'b1;
            start_idx = sdspi_pkg::IDX_WRITE_BLOCK;
            start_arg = st_item_r.block_address;
          end
        end
        sdspi_pkg::CMD_CARD: begin
          unique case (phase_r)
            sdspi_pkg::PH_IDLE: begin
              // Card byte while idle is dropped.
            end
            sdspi_pkg::PH_DUMMY: begin
              byte_counter_nxt = cnt_inc;
              if (cnt_inc < sdspi_pkg::DUMMY_BYTES) begin
                res_valid    = 1'b1;
                res.tx_byte  = sdspi_pkg::IDLE_BYTE;
                res.tx_valid = 1'b1;
              end else begin
                start     = 1'b1;
                start_idx = sdspi_pkg::IDX_GO_IDLE;
                start_arg = sdspi_pkg::ARG_NONE;
              end
            end
            sdspi_pkg::PH_CMD: begin
              byte_counter_nxt  = cnt_inc;
              res_valid         = 1'b1;
              res.tx_valid      = 1'b1;
              res.select_active = 1'b1;
              if (cnt_inc < sdspi_pkg::CMD_BYTES) begin
                res.tx_byte = sdspi_pkg::frame_byte(cnt_inc[2:0], current_index_r,
                                                    current_argument_r);
              end else begin
                phase_nxt        = sdspi_pkg::PH_POLL;
                poll_counter_nxt = '0;
                res.tx_byte      = sdspi_pkg::IDLE_BYTE;
              end
            end
            sdspi_pkg::PH_POLL: begin
              poll_counter_nxt   = poll_inc;
              saved_response_nxt = b;
              if (b[7] && (poll_inc < sdspi_pkg::POLL_LIMIT)) begin
                res_valid         = 1'b1;
                res.tx_byte       = sdspi_pkg::IDLE_BYTE;
                res.tx_valid      = 1'b1;
                res.select_active = 1'b1;
              end else if (current_index_r == sdspi_pkg::IDX_WRITE_BLOCK) begin
                if (b != sdspi_pkg::R1_READY) begin
                  end_op     = 1'b1;
                  end_status = sdspi_pkg::ST_WR_REJ;
                end else begin
                  phase_nxt         = sdspi_pkg::PH_TOKEN;
                  res_valid         = 1'b1;
                  res.tx_byte       = sdspi_pkg::START_TOKEN;
                  res.tx_valid      = 1'b1;
                  res.select_active = 1'b1;
                end
              end else begin
                end_op     = 1'b1;
                end_status = sdspi_pkg::ST_OK;
              end
            end
            sdspi_pkg::PH_END: begin
              // Either finish or chain the next init command.
              res_valid = 1'b1;
              unique case (current_index_r)
                sdspi_pkg::IDX_WRITE_BLOCK: begin
                  phase_nxt    = sdspi_pkg::PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = byte_counter_r[1:0];
                end
                sdspi_pkg::IDX_GO_IDLE: begin
                  if (saved_response_r != sdspi_pkg::R1_IDLE) begin
                    phase_nxt    = sdspi_pkg::PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = sdspi_pkg::ST_IDLE_ERR;
                  end else begin
                    start     = 1'b1;
                    start_idx = sdspi_pkg::IDX_IF_COND;
                    start_arg = sdspi_pkg::ARG_IF_COND;
                  end
                end
                sdspi_pkg::IDX_IF_COND: begin
                  start     = 1'b1;
                  start_idx = sdspi_pkg::IDX_APP_CMD;
                  start_arg = sdspi_pkg::ARG_NONE;
                end
                sdspi_pkg::IDX_APP_CMD: begin
                  start     = 1'b1;
                  start_idx = sdspi_pkg::IDX_OP_COND;
                  start_arg = sdspi_pkg::ARG_OP_COND;
                end
                sdspi_pkg::IDX_OP_COND: begin
                  if (saved_response_r == sdspi_pkg::R1_READY) begin
                    phase_nxt    = sdspi_pkg::PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = sdspi_pkg::ST_OK;
                  end else begin
                    start     = 1'b1;
                    start_idx = sdspi_pkg::IDX_APP_CMD;
                    start_arg = sdspi_pkg::ARG_NONE;
                  end
                end
                default: begin
                  phase_nxt    = sdspi_pkg::PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = sdspi_pkg::ST_OK;
                end
              endcase
            end
            sdspi_pkg::PH_TOKEN: begin
              phase_nxt         = sdspi_pkg::PH_DATA;
              byte_counter_nxt  = '0;
              res_valid         = 1'b1;
              res.tx_byte       = rd_data_r;
              res.tx_valid      = 1'b1;
              res.select_active = 1'b1;
            end
            sdspi_pkg::PH_DATA: begin
              res_valid         = 1'b1;
              res.tx_valid      = 1'b1;
              res.select_active = 1'b1;
              if (cnt_inc < sdspi_pkg::BLOCK_BYTES) begin
                byte_counter_nxt = cnt_inc;
                res.tx_byte      = rd_data_r;
              end else begin
                phase_nxt        = sdspi_pkg::PH_CRC;
                byte_counter_nxt = '0;
                res.tx_byte      = sdspi_pkg::IDLE_BYTE;
              end
            end
            sdspi_pkg::PH_CRC: begin
              byte_counter_nxt  = cnt_inc;
              if (cnt_inc >= sdspi_pkg::CRC_BYTES) begin
                phase_nxt = sdspi_pkg::PH_DRESP;
              end
              res_valid         = 1'b1;
              res.tx_byte       = sdspi_pkg::IDLE_BYTE;
              res.tx_valid      = 1'b1;
              res.select_active = 1'b1;
            end
            sdspi_pkg::PH_DRESP: begin
              saved_response_nxt = b;
              if (b[4:0] != sdspi_pkg::DRESP_MASKED_OK) begin
                end_op     = 1'b1;
                end_status = sdspi_pkg::ST_DATA_REJ;
              end else begin
                phase_nxt         = sdspi_pkg::PH_BUSY;
                res_valid         = 1'b1;
                res.tx_byte       = sdspi_pkg::IDLE_BYTE;
                res.tx_valid      = 1'b1;
                res.select_active = 1'b1;
              end
            end
            sdspi_pkg::PH_BUSY: begin
              // The card holds the line low while it programs the block.
              if (b == 8'h00) begin
                res_valid         = 1'b1;
                res.tx_byte       = sdspi_pkg::IDLE_BYTE;
                res.tx_valid      = 1'b1;
                res.select_active = 1'b1;
              end else begin
                end_op     = 1'b1;
                end_status = sdspi_pkg::ST_OK;
              end
            end
            default: begin
              phase_nxt = sdspi_pkg::PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase

      // Start of a command frame: first byte goes out with select asserted.
      if (start) begin
        current_index_nxt    = start_idx;
        current_argument_nxt = start_arg;
        phase_nxt            = sdspi_pkg::PH_CMD;
        byte_counter_nxt     = '0;
        poll_counter_nxt     = '0;
        res_valid            = 1'b1;
        res                  = '0;
        res.tx_byte          = sdspi_pkg::frame_byte(3'd0, start_idx, start_arg);
        res.tx_valid         = 1'b1;
        res.select_active    = 1'b1;
      end

      // End of an operation: release select for one byte, keep the status.
      if (end_op) begin
        phase_nxt        = sdspi_pkg::PH_END;
        byte_counter_nxt = {8'h00, end_status};
        res_valid        = 1'b1;
        res              = '0;
        res.tx_byte      = sdspi_pkg::IDLE_BYTE;
        res.tx_valid     = 1'b1;
      end
    end
  end

  // Prefetch address follows the state that the next card byte will see.
  assign rd_addr = (phase_nxt == sdspi_pkg::PH_TOKEN) ? '0
                 : byte_counter_nxt[sdspi_pkg::ADDR_W-1:0] + 9'd1;

  // Payload memory with write-to-read forwarding.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem[st_item_r.payload_index] <= st_item_r.payload_byte;
    end
    if (wr_en && (st_item_r.payload_index == rd_addr)) begin
      rd_data_r <= st_item_r.payload_byte;
    end else begin
      rd_data_r <= payload_mem[rd_addr];
    end
  end

  // Stage register and sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r         <= 1'b0;
      phase_r            <= sdspi_pkg::PH_IDLE;
      byte_counter_r     <= '0;
      poll_counter_r     <= '0;
      current_argument_r <= '0;
      current_index_r    <= '0;
      saved_response_r   <= 8'hFF;
    end else begin
      if (in_ready) begin
        st_valid_r <= in_valid;
      end
      phase_r            <= phase_nxt;
      byte_counter_r     <= byte_counter_nxt;
      poll_counter_r     <= poll_counter_nxt;
      current_argument_r <= current_argument_nxt;
      current_index_r    <= current_index_nxt;
      saved_response_r   <= saved_response_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      st_item_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_data_r <= res;
    end
  end

  // A completion word always returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res_valid && res.done_res) |=> (phase_r == sdspi_pkg::PH_IDLE))
    else $error("completion did not return to idle");

  // The data phase never runs past the block.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sdspi_pkg::PH_DATA) |-> (byte_counter_r < sdspi_pkg::BLOCK_BYTES))
    else $error("data byte counter out of range");

  // Polling stays within its retry limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sdspi_pkg::PH_POLL) |-> (poll_counter_r < sdspi_pkg::POLL_LIMIT))
    else $error("poll counter out of range");

endmodule

`default_nettype wire

/* tb/sv/sd_card_spi_host_sequencer_test.sv */
// Self-checking testbench for the SD card SPI-mode host sequencer.
// Depends on sdspi_pkg and sd_card_spi_host_sequencer; a scoreboard class predicts
// every result word while plain functions and tasks play the card and an always block the result consumer.
module sd_card_spi_host_sequencer_test;
  import sdspi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 900;

  // Scoreboard: a behavioral copy of the sequencer and the queue of words it owes.
  class exchange_board;
    phase_t     phase;
    logic [9:0] byte_cnt;
    logic [3:0] poll_cnt;
    logic [31:0] cmd_arg;
    logic [5:0] cmd_idx;
    logic [7:0] last_reply;
    status_t    end_status;
    logic [7:0] payload [512];
    out_t       due_words [$];
    int         mismatches;

    function new();
      phase = PH_IDLE;
      byte_cnt = '0;
      poll_cnt = '0;
      cmd_arg = ARG_NONE;
      cmd_idx = IDX_GO_IDLE;
      last_reply = IDLE_BYTE;
      end_status = ST_OK;
      mismatches = 0;
    endfunction

    function out_t send_byte(logic [7:0] b, logic sel);
      out_t r;
      r = '0;
      r.tx_byte = b;
      r.tx_valid = 1'b1;
      r.select_active = sel;
      return r;
    endfunction

    function out_t finish_op(status_t st);
      out_t r;
      r = '0;
      phase = PH_IDLE;
      r.done_res = 1'b1;
      r.status = st;
      return r;
    endfunction

    // Byte k of the current command frame: index, argument MSB first, then CRC.
    function logic [7:0] frame_octet(int k);
      logic [47:0] frame;
      logic [7:0] crc;
      if (cmd_idx == IDX_GO_IDLE) begin
        crc = CRC_CMD0;
      end else if (cmd_idx == IDX_IF_COND) begin
        crc = CRC_CMD8;
      end else begin
        crc = CRC_OTHER;
      end
      frame = {CMD_PREFIX | {2'b00, cmd_idx}, cmd_arg, crc};
      return frame[40 - 8 * k +: 8];
    endfunction

    function out_t open_cmd(logic [5:0] idx, logic [31:0] arg);
      cmd_idx = idx;
      cmd_arg = arg;
      phase = PH_CMD;
      byte_cnt = '0;
      poll_cnt = '0;
      return send_byte(frame_octet(0), 1'b1);
    endfunction

    // Release select for one trailing byte; the status is reported after it.
    function out_t close_op(status_t st);
      phase = PH_END;
      end_status = st;
      return send_byte(IDLE_BYTE, 1'b0);
    endfunction

    // Decide what follows the trailing byte of a command.
    function out_t end_step();
      case (cmd_idx)
        IDX_WRITE_BLOCK: return finish_op(end_status);
        IDX_GO_IDLE: begin
          if (last_reply != R1_IDLE) return finish_op(ST_IDLE_ERR);
          return open_cmd(IDX_IF_COND, ARG_IF_COND);
        end
        IDX_IF_COND: return open_cmd(IDX_APP_CMD, ARG_NONE);
        IDX_APP_CMD: return open_cmd(IDX_OP_COND, ARG_OP_COND);
        IDX_OP_COND: begin
          if (last_reply == R1_READY) return finish_op(ST_OK);
          return open_cmd(IDX_APP_CMD, ARG_NONE);
        end
        default: return finish_op(ST_OK);
      endcase
    endfunction

    // One input word; returns 1 when it produces a result word.
    function bit advance(in_t w, output out_t r);
      logic [7:0] b;
      b = w.card_byte;
      r = '0;
      case (w.command)
        CMD_LOAD: begin
          payload[w.payload_index] = w.payload_byte;
          return 1'b0;
        end
        CMD_INIT: begin
          if (phase != PH_IDLE) return 1'b0;
          phase = PH_DUMMY;
          byte_cnt = '0;
          r = send_byte(IDLE_BYTE, 1'b0);
          return 1'b1;
        end
        CMD_WRITE: begin
          if (phase != PH_IDLE) return 1'b0;
          r = open_cmd(IDX_WRITE_BLOCK, w.block_address);
          return 1'b1;
        end
        default: ;
      endcase
      case (phase)
        PH_DUMMY: begin
          byte_cnt++;
          if (byte_cnt < DUMMY_BYTES) r = send_byte(IDLE_BYTE, 1'b0);
          else r = open_cmd(IDX_GO_IDLE, ARG_NONE);
        end
        PH_CMD: begin
          byte_cnt++;
          if (byte_cnt < CMD_BYTES) begin
            r = send_byte(frame_octet(int'(byte_cnt)), 1'b1);
          end else begin
            phase = PH_POLL;
            poll_cnt = '0;
            r = send_byte(IDLE_BYTE, 1'b1);
          end
        end
        PH_POLL: begin
          poll_cnt++;
          last_reply = b;
          if (b[7] && poll_cnt < POLL_LIMIT) begin
            r = send_byte(IDLE_BYTE, 1'b1);
          end else if (cmd_idx != IDX_WRITE_BLOCK) begin
            r = close_op(ST_OK);
          end else if (b != R1_READY) begin
            r = close_op(ST_WR_REJ);
          end else begin
            phase = PH_TOKEN;
            r = send_byte(START_TOKEN, 1'b1);
          end
        end
        PH_END: r = end_step();
        PH_TOKEN: begin
          phase = PH_DATA;
          byte_cnt = '0;
          r = send_byte(payload[0], 1'b1);
        end
        PH_DATA: begin
          byte_cnt++;
          if (byte_cnt < BLOCK_BYTES) begin
            r = send_byte(payload[byte_cnt[8:0]], 1'b1);
          end else begin
            phase = PH_CRC;
            byte_cnt = '0;
            r = send_byte(IDLE_BYTE, 1'b1);
          end
        end
        PH_CRC: begin
          byte_cnt++;
          if (byte_cnt >= CRC_BYTES) phase = PH_DRESP;
          r = send_byte(IDLE_BYTE, 1'b1);
        end
        PH_DRESP: begin
          last_reply = b;
          if (b[4:0] != DRESP_MASKED_OK) begin
            r = close_op(ST_DATA_REJ);
          end else begin
            phase = PH_BUSY;
            r = send_byte(IDLE_BYTE, 1'b1);
          end
        end
        PH_BUSY: begin
          // The card holds the line at zero while it programs the block.
          if (b == 8'h00) r = send_byte(IDLE_BYTE, 1'b1);
          else r = close_op(ST_OK);
        end
        default: begin
          phase = PH_IDLE;
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    // Accepted input word; returns 1 when the word was not simply ignored.
    function bit note_word(in_t w);
      out_t r;
      bit has_result;
      has_result = advance(w, r);
      if (has_result) due_words.push_back(r);
      return has_result || (w.command == CMD_LOAD);
    endfunction

    // Accepted result word against the oldest prediction.
    function void check_word(out_t got);
      out_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: tx_byte=%h tx_valid=%b sel=%b done=%b %s%0d",
                   got.tx_byte, got.tx_valid, got.select_active, got.done_res,
                   "status=", got.status);
        return;
      end
      want = due_words.pop_front();
      if (got.tx_byte != want.tx_byte || got.tx_valid != want.tx_valid ||
          got.select_active != want.select_active || got.done_res != want.done_res ||
          got.status != want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want tx_byte=%h tx_valid=%b sel=%b done=%b status=%0d",
                   want.tx_byte, want.tx_valid, want.select_active, want.done_res,
                   want.status);
          $display("           got tx_byte=%h tx_valid=%b sel=%b done=%b status=%0d",
                   got.tx_byte, got.tx_valid, got.select_active, got.done_res,
                   got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  exchange_board sb;
  int cycles = 0;
  int effective_words = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit silent_card = 1'b0;

  sd_card_spi_host_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check every accepted word and stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_word(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Random word with the given command; all other fields are noise.
  function automatic in_t rand_word(logic [1:0] c);
    in_t w;
    w.command = c;
    w.block_address = $urandom;
    w.payload_index = 9'($urandom);
    w.payload_byte = 8'($urandom);
    w.card_byte = 8'($urandom);
    return w;
  endfunction

  function automatic in_t card_word(logic [7:0] b);
    in_t w;
    w = rand_word(CMD_CARD);
    w.card_byte = b;
    return w;
  endfunction

  // Card answer during response polling, shaped per command.
  function automatic logic [7:0] poll_reply();
    if (silent_card || $urandom_range(99) < 25) return {1'b1, 7'($urandom)};
    case (sb.cmd_idx)
      IDX_GO_IDLE: return ($urandom_range(9) != 0) ? R1_IDLE : {1'b0, 7'($urandom)};
      IDX_OP_COND: return ($urandom_range(99) < 40) ? R1_READY : R1_IDLE;
      IDX_WRITE_BLOCK: return ($urandom_range(99) < 85) ? R1_READY : {1'b0, 7'($urandom)};
      // Replies to CMD8 and CMD55 are not inspected.
      default: return {1'b0, 7'($urandom)};
    endcase
  endfunction

  // Next word of a mostly well-formed card conversation.
  function automatic in_t next_word();
    in_t w;
    int pick;
    w = rand_word(CMD_CARD);
    pick = $urandom_range(99);
    // A few words are noise: stray starts, loads and card bytes anywhere.
    if (pick < 4) begin
      w.command = 2'($urandom);
      return w;
    end
    case (sb.phase)
      PH_IDLE: begin
        if (pick < 50) begin
          w.command = CMD_INIT;
        end else if (pick < 92) begin
          w.command = CMD_WRITE;
          case ($urandom_range(3))
            0: w.block_address = '0;
            1: w.block_address = '1;
            default: ;
          endcase
        end else if (pick < 96) begin
          w.command = CMD_LOAD;
        end
      end
      PH_CMD: silent_card = ($urandom_range(19) == 0);
      PH_POLL: w.card_byte = poll_reply();
      PH_DRESP: begin
        if ($urandom_range(99) < 80) w.card_byte = {3'($urandom), DRESP_MASKED_OK};
      end
      PH_BUSY: begin
        w.card_byte = ($urandom_range(99) < 70) ? 8'h00 : 8'($urandom_range(255, 1));
      end
      default: ;
    endcase
    return w;
  endfunction

  // Present one word, idling first at the current rate, and wait for acceptance.
  task automatic send_word(input in_t w);
    if (effective_words < 700) begin
      send_idle_pct = 21;
      recv_idle_pct = 74;
    end else if (effective_words < 1400) begin
      send_idle_pct = 74;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_word(w)) effective_words++;
  endtask

  initial begin
    in_t w;
    int random_start;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Card bytes while idle, with every field at its extremes.
    w = '0;
    w.command = CMD_CARD;
    send_word(w);
    w = '1;
    w.command = CMD_CARD;
    send_word(w);

    // Fill the whole payload buffer before any block write.
    for (int i = 0; i < 512; i++) begin
      w = rand_word(CMD_LOAD);
      w.payload_index = 9'(i);
      send_word(w);
    end

    // Init whose CMD0 is answered with random bytes, with starts issued while busy.
    send_word(rand_word(CMD_INIT));
    for (int i = 0; i < 10; i++) begin
      if (i == 5) begin
        send_word(rand_word(CMD_WRITE));
        send_word(rand_word(CMD_INIT));
      end
      send_word(card_word(8'($urandom)));
    end
    for (int i = 0; i < 5; i++) send_word(card_word(8'($urandom)));
    send_word(card_word(8'h00));
    send_word(card_word(8'($urandom)));
    send_word(card_word(8'($urandom)));

    // Random conversations: init loops, block writes and rejections.
    random_start = effective_words;
    while (effective_words - random_start < RANDOM_WORDS) send_word(next_word());
    in_valid <= 1'b0;

    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
